### rtl/kot_pkg.sv
package kot_pkg;

  localparam int unsigned TableDepthDefault = 64;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned ValueW = 32;
  localparam int unsigned PosW   = 6;
  localparam int unsigned CountW = 7;

  typedef enum logic [2:0] {
    CmdInsert = 3'd0,
    CmdFind   = 3'd1,
    CmdErase  = 3'd2,
    CmdRead   = 3'd3,
    CmdClear  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StNotFound  = 2'd1,
    StDuplicate = 2'd2,
    StFull      = 2'd3
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [KeyW-1:0]     key;
    logic [ValueW-1:0]   value;
    logic [CountW-1:0]   count;
  } res_t;

endpackage

### rtl/kot_store.sv
module kot_store #(
  parameter int unsigned TABLE_DEPTH = kot_pkg::TableDepthDefault,
  localparam int unsigned IW = $clog2(TABLE_DEPTH)
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [IW-1:0]             waddr_i,
  input  logic [kot_pkg::KeyW-1:0]  wkey_i,
  input  logic [kot_pkg::ValueW-1:0] wval_i,
  input  logic [IW-1:0]             raddr_i,
  output logic [kot_pkg::KeyW-1:0]  rkey_o,
  output logic [kot_pkg::ValueW-1:0] rval_o
);

  logic [kot_pkg::KeyW-1:0]   key_mem [TABLE_DEPTH];
  logic [kot_pkg::ValueW-1:0] val_mem [TABLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      key_mem[waddr_i] <= wkey_i;
      val_mem[waddr_i] <= wval_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rkey_o <= key_mem[raddr_i];
    rval_o <= val_mem[raddr_i];
  end

endmodule

### rtl/kot_seq.sv
module kot_seq #(
  parameter int unsigned TABLE_DEPTH = kot_pkg::TableDepthDefault,
  localparam int unsigned IW = $clog2(TABLE_DEPTH),
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1),
  localparam int unsigned SW = $clog2(TABLE_DEPTH + 2),
  localparam int unsigned PW = (CW > kot_pkg::PosW) ? CW : kot_pkg::PosW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  command_i,
  input  logic [kot_pkg::KeyW-1:0]    key_i,
  input  logic [kot_pkg::ValueW-1:0]  value_i,
  input  logic [kot_pkg::PosW-1:0]    position_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output kot_pkg::res_t               res_o,
  output logic                        we_o,
  output logic [IW-1:0]               waddr_o,
  output logic [kot_pkg::KeyW-1:0]    wkey_o,
  output logic [kot_pkg::ValueW-1:0]  wval_o,
  output logic [IW-1:0]               raddr_o,
  input  logic [kot_pkg::KeyW-1:0]    rkey_i,
  input  logic [kot_pkg::ValueW-1:0]  rval_i
);

  typedef enum logic [4:0] {
    SIdle  = 5'b00001,
    SSrch  = 5'b00010,
    SShift = 5'b00100,
    SRead  = 5'b01000,
    SResp  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [SW-1:0] idx_q, idx_d;
  logic          pend_q, pend_d;
  logic [CW-1:0] count_q, count_d;

  logic [2:0]                 cmd_q;
  logic [kot_pkg::KeyW-1:0]   key_q;
  logic [kot_pkg::ValueW-1:0] val_q;

  kot_pkg::status_e           status_q, status_d;
  logic [kot_pkg::KeyW-1:0]   okey_q, okey_d;
  logic [kot_pkg::ValueW-1:0] oval_q, oval_d;

  logic issue;
  logic hit;

  assign issue = idx_q < SW'(count_q);
  assign hit   = pend_q && (rkey_i == key_q);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pend_d      = 1'b0;
    count_d     = count_q;
    status_d    = status_q;
    okey_d      = okey_q;
    oval_d      = oval_q;
    we_o        = 1'b0;
    waddr_o     = IW'(count_q);
    wkey_o      = key_q;
    wval_o      = val_q;
    raddr_o     = IW'(idx_q);
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          idx_d    = '0;
          status_d = kot_pkg::StOk;
          okey_d   = '0;
          oval_d   = '0;
          case (command_i)
            kot_pkg::CmdInsert, kot_pkg::CmdFind, kot_pkg::CmdErase: begin
              state_d = SSrch;
            end
            kot_pkg::CmdRead: begin
              raddr_o = IW'(position_i);
              if (PW'(position_i) < PW'(count_q)) begin
                state_d = SRead;
              end else begin
                status_d = kot_pkg::StNotFound;
                state_d  = SResp;
              end
            end
            kot_pkg::CmdClear: begin
              count_d = '0;
              state_d = SResp;
            end
            default: begin
              status_d = kot_pkg::StNotFound;
              state_d  = SResp;
            end
          endcase
        end
      end

      SSrch: begin
        if (hit) begin
          state_d = SResp;
          case (cmd_q)
            kot_pkg::CmdInsert: status_d = kot_pkg::StDuplicate;
            kot_pkg::CmdFind:   oval_d   = rval_i;
            kot_pkg::CmdErase: begin
              // idx_q already points one past the matching slot
              state_d = SShift;
            end
            default: status_d = kot_pkg::StNotFound;
          endcase
        end else if (!pend_q && !issue) begin
          state_d = SResp;
          if (cmd_q == kot_pkg::CmdInsert) begin
            if (SW'(count_q) >= SW'(TABLE_DEPTH)) begin
              status_d = kot_pkg::StFull;
            end else begin
              we_o    = 1'b1;
              count_d = CW'(count_q + 1'b1);
            end
          end else begin
            status_d = kot_pkg::StNotFound;
          end
        end else begin
          pend_d = issue;
          idx_d  = SW'(idx_q + 1'b1);
        end
      end

      SShift: begin
        // move the entry read last cycle down by one slot
        if (pend_q) begin
          we_o    = 1'b1;
          waddr_o = IW'(idx_q - SW'(2));
          wkey_o  = rkey_i;
          wval_o  = rval_i;
        end
        if (!pend_q && !issue) begin
          count_d = CW'(count_q - 1'b1);
          state_d = SResp;
        end else begin
          pend_d = issue;
          idx_d  = SW'(idx_q + 1'b1);
        end
      end

      SRead: begin
        okey_d  = rkey_i;
        oval_d  = rval_i;
        state_d = SResp;
      end

      SResp: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = SIdle;
        end
      end

      default: state_d = SIdle;
    endcase
  end

  always_comb begin
    res_o.status = status_q;
    res_o.key    = okey_q;
    res_o.value  = oval_q;
    res_o.count  = kot_pkg::CountW'(count_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      idx_q   <= '0;
      pend_q  <= 1'b0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pend_q  <= pend_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && in_valid_i) begin
      cmd_q <= command_i;
      key_q <= key_i;
      val_q <= value_i;
    end
    status_q <= status_d;
    okey_q   <= okey_d;
    oval_q   <= oval_d;
  end

endmodule

### rtl/int_key_ordered_table.sv
// Insertion-ordered key/value table with 32-bit keys, up to TABLE_DEPTH entries.
// Input channel (in_valid_i/in_ready_o) carries one command beat: insert, find,
// erase, read by position or clear. Output channel (out_valid_o/out_ready_i)
// returns exactly one result beat per command: status, key, value and the
// entry count after the operation.
// One command is worked at a time; in_ready_o is high only while the sequencer
// is idle. Insert and find compare the entries in order (one shared key compare
// per entry, fed by the single read port of the entry memory); erase searches,
// then moves one entry per cycle. Read by position reads one entry; clear, an
// unknown command or a bad position go straight to the result. The sequencer
// takes the next command in the cycle after its result has left, even while
// that result still waits in the output register.
// If the receiver stalls, the result holds in the output register and a second
// finished result holds in the sequencer, which then takes no new beat.
// Reset empties the table at once (count to zero); the entry memory is not
// cleared and needs no clearing pass.
module int_key_ordered_table #(
  parameter int unsigned TABLE_DEPTH = kot_pkg::TableDepthDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [2:0]                         command_i,
  input  logic signed [kot_pkg::KeyW-1:0]    key_i,
  input  logic [kot_pkg::ValueW-1:0]         value_i,
  input  logic [kot_pkg::PosW-1:0]           position_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         result_status_o,
  output logic signed [kot_pkg::KeyW-1:0]    found_key_o,
  output logic [kot_pkg::ValueW-1:0]         found_value_o,
  output logic [kot_pkg::CountW-1:0]         entry_count_o
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);

  kot_pkg::res_t res;
  kot_pkg::res_t out_q;
  logic          res_valid;
  logic          res_ready;
  logic          out_valid_q;

  logic                        we;
  logic [IW-1:0]               waddr;
  logic [kot_pkg::KeyW-1:0]    wkey;
  logic [kot_pkg::ValueW-1:0]  wval;
  logic [IW-1:0]               raddr;
  logic [kot_pkg::KeyW-1:0]    rkey;
  logic [kot_pkg::ValueW-1:0]  rval;

  kot_seq #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .key_i       (key_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .we_o        (we),
    .waddr_o     (waddr),
    .wkey_o      (wkey),
    .wval_o      (wval),
    .raddr_o     (raddr),
    .rkey_i      (rkey),
    .rval_i      (rval)
  );

  kot_store #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wkey_i  (wkey),
    .wval_i  (wval),
    .raddr_i (raddr),
    .rkey_o  (rkey),
    .rval_o  (rval)
  );

  // output register: load when empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_status_o = out_q.status;
  assign found_key_o     = out_q.key;
  assign found_value_o   = out_q.value;
  assign entry_count_o   = out_q.count;

endmodule

### bench/int_key_ordered_table_tb.sv
`timescale 1ns / 1ps

module int_key_ordered_table_tb;

  localparam int unsigned TableDepth = kot_pkg::TableDepthDefault;
  localparam int unsigned KeyW = kot_pkg::KeyW;
  localparam int unsigned ValueW = kot_pkg::ValueW;
  localparam int unsigned PosW = kot_pkg::PosW;
  localparam int unsigned CountW = kot_pkg::CountW;
  localparam int unsigned PoolSize = 48;
  localparam int unsigned RandomItems = 1200;
  localparam int unsigned IdlePercent = 37;
  localparam int unsigned HoldStart = 300;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned CalmFirst = 500;
  localparam int unsigned CalmLast = 700;
  localparam int unsigned DrainCycles = 2 * TableDepth + 20;
  localparam logic [2:0] CmdUnknownLo = 3'd5;
  localparam logic [2:0] CmdUnknownHi = 3'd7;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [KeyW-1:0]   key;
    logic [ValueW-1:0] value;
    logic [PosW-1:0]   pos;
  } command_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [2:0] command_i = '0;
  logic signed [KeyW-1:0] key_i = '0;
  logic [ValueW-1:0] value_i = '0;
  logic [PosW-1:0] position_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] result_status_o;
  logic signed [KeyW-1:0] found_key_o;
  logic [ValueW-1:0] found_value_o;
  logic [CountW-1:0] entry_count_o;

  command_beat_t pending_commands[$];
  kot_pkg::res_t expected_results[$];

  // shadow copy of the table, updated in acceptance order
  logic [KeyW-1:0] shadow_keys [TableDepth];
  logic [ValueW-1:0] shadow_values [TableDepth];
  int unsigned shadow_count = 0;

  logic [KeyW-1:0] key_pool [PoolSize];
  logic in_beat_taken = 1'b0;
  int unsigned accepted_beats = 0;
  int unsigned results_checked = 0;
  int unsigned error_count = 0;
  int unsigned hold_left = 0;
  logic hold_done = 1'b0;
  int unsigned cmd_tally [8];
  int unsigned status_tally [4];
  logic calm_stretch;

  assign calm_stretch = accepted_beats >= CalmFirst && accepted_beats < CalmLast;

  int_key_ordered_table #(
    .TABLE_DEPTH(TableDepth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .key_i          (key_i),
    .value_i        (value_i),
    .position_i     (position_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_status_o(result_status_o),
    .found_key_o    (found_key_o),
    .found_value_o  (found_value_o),
    .entry_count_o  (entry_count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #15_000_000;
    $display("FAIL int_key_ordered_table");
    $finish;
  end

  function automatic void queue_command(input logic [2:0] cmd,
                                        input logic [KeyW-1:0] key,
                                        input logic [ValueW-1:0] value,
                                        input logic [PosW-1:0] pos);
    command_beat_t beat;
    beat.cmd = cmd;
    beat.key = key;
    beat.value = value;
    beat.pos = pos;
    pending_commands.push_back(beat);
  endfunction

  // apply one command to the shadow table and return the result it must give
  function automatic kot_pkg::res_t apply_command(input logic [2:0] cmd,
                                                  input logic [KeyW-1:0] key,
                                                  input logic [ValueW-1:0] value,
                                                  input logic [PosW-1:0] pos);
    kot_pkg::res_t r;
    int slot;
    r = '0;
    r.status = kot_pkg::StOk;
    slot = -1;
    for (int i = 0; i < shadow_count; i++) begin
      if (slot < 0 && shadow_keys[i] == key) slot = i;
    end
    case (cmd)
      kot_pkg::CmdInsert: begin
        if (slot >= 0) begin
          r.status = kot_pkg::StDuplicate;
        end else if (shadow_count >= TableDepth) begin
          r.status = kot_pkg::StFull;
        end else begin
          shadow_keys[shadow_count] = key;
          shadow_values[shadow_count] = value;
          shadow_count++;
        end
      end
      kot_pkg::CmdFind: begin
        if (slot >= 0) r.value = shadow_values[slot];
        else r.status = kot_pkg::StNotFound;
      end
      kot_pkg::CmdErase: begin
        if (slot >= 0) begin
          // close the gap, keeping insertion order
          for (int i = slot; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i + 1];
            shadow_values[i] = shadow_values[i + 1];
          end
          shadow_count--;
        end else begin
          r.status = kot_pkg::StNotFound;
        end
      end
      kot_pkg::CmdRead: begin
        if (pos < shadow_count) begin
          r.key = shadow_keys[pos];
          r.value = shadow_values[pos];
        end else begin
          r.status = kot_pkg::StNotFound;
        end
      end
      kot_pkg::CmdClear: shadow_count = 0;
      default: r.status = kot_pkg::StNotFound;
    endcase
    r.count = CountW'(shadow_count);
    cmd_tally[cmd]++;
    status_tally[r.status]++;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("%0t mismatch on %s: got %h, want %h (result %0d)",
             $time, field, got, want, results_checked);
  endtask

  function automatic logic roll_idle();
    return !calm_stretch && $urandom_range(0, 99) < IdlePercent;
  endfunction

  // command driver: hold the beat until taken, then offer the next or idle
  always @(negedge clk_i) begin : drive_commands
    command_beat_t beat;
    if (rst_ni) begin
      if (!in_valid_i || in_beat_taken) begin
        if (pending_commands.size() > 0 && !roll_idle()) begin
          beat = pending_commands.pop_front();
          in_valid_i <= 1'b1;
          command_i <= beat.cmd;
          key_i <= beat.key;
          value_i <= beat.value;
          position_i <= beat.pos;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result receiver, with one long hold-off to fill the block up
  always @(negedge clk_i) begin : drive_ready
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else if (!hold_done && accepted_beats >= HoldStart) begin
        hold_left <= HoldCycles;
        hold_done <= 1'b1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !roll_idle();
      end
    end
  end

  always @(posedge clk_i) begin : watch_beats
    kot_pkg::res_t want;
    if (rst_ni) begin
      in_beat_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(apply_command(command_i, key_i, value_i, position_i));
        accepted_beats <= accepted_beats + 1;
      end
      if (out_valid_o && out_ready_i) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, status", result_status_o, '0);
        end else begin
          want = expected_results.pop_front();
          if (result_status_o !== want.status)
            report_mismatch("status", result_status_o, want.status);
          if (found_key_o !== want.key) report_mismatch("key", found_key_o, want.key);
          if (found_value_o !== want.value) report_mismatch("value", found_value_o, want.value);
          if (entry_count_o !== want.count) report_mismatch("count", entry_count_o, want.count);
        end
      end
    end
  end

  initial begin : run_control
    logic [KeyW-1:0] base;
    logic [KeyW-1:0] stride;
    logic [2:0] cmd;
    int unsigned pick;
    int unsigned target;

    foreach (cmd_tally[i]) cmd_tally[i] = 0;
    foreach (status_tally[i]) status_tally[i] = 0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;

    // directed: empty table, extremes, duplicate, compaction, unknown codes, clear
    queue_command(kot_pkg::CmdFind, 32'h8000_0000, '0, '0);
    queue_command(kot_pkg::CmdErase, 32'h7fff_ffff, '0, '0);
    queue_command(kot_pkg::CmdRead, '0, '0, 6'd0);
    queue_command(kot_pkg::CmdRead, '0, '0, 6'd63);
    queue_command(kot_pkg::CmdInsert, 32'h8000_0000, 32'h0000_0000, 6'd0);
    queue_command(kot_pkg::CmdInsert, 32'h7fff_ffff, 32'hffff_ffff, 6'd63);
    queue_command(kot_pkg::CmdInsert, 32'h0000_0000, 32'h5555_5555, 6'd0);
    queue_command(kot_pkg::CmdInsert, 32'hffff_ffff, 32'haaaa_aaaa, 6'd0);
    queue_command(kot_pkg::CmdInsert, 32'h7fff_ffff, 32'h1234_5678, 6'd0);
    queue_command(kot_pkg::CmdFind, 32'h7fff_ffff, 32'hffff_ffff, 6'd63);
    queue_command(kot_pkg::CmdFind, 32'h0000_0001, '0, '0);
    queue_command(kot_pkg::CmdRead, '0, '0, 6'd0);
    queue_command(kot_pkg::CmdRead, '0, '0, 6'd3);
    queue_command(kot_pkg::CmdRead, '0, '0, 6'd4);
    queue_command(kot_pkg::CmdErase, 32'h0000_0000, '0, '0);
    queue_command(kot_pkg::CmdRead, '0, '0, 6'd2);
    queue_command(kot_pkg::CmdErase, 32'h8000_0000, '0, '0);
    queue_command(kot_pkg::CmdErase, 32'hffff_ffff, '0, '0);
    for (int c = CmdUnknownLo; c <= CmdUnknownHi; c++) begin
      queue_command(3'(c), 32'h7fff_ffff, 32'hffff_ffff, 6'd0);
    end
    queue_command(kot_pkg::CmdClear, 32'hffff_ffff, 32'hffff_ffff, 6'd63);
    queue_command(kot_pkg::CmdFind, 32'h7fff_ffff, '0, '0);
    queue_command(kot_pkg::CmdRead, '0, '0, 6'd0);

    target = pending_commands.size() + RandomItems;
    while (pending_commands.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        // fill to full with distinct keys, then probe, punch holes and refill
        base = $urandom;
        stride = $urandom | 32'h1;
        queue_command(kot_pkg::CmdClear, $urandom, $urandom, 6'($urandom));
        for (int i = 0; i < TableDepth + 2; i++) begin
          queue_command(kot_pkg::CmdInsert, base + i * stride, $urandom, 6'($urandom));
        end
        queue_command(kot_pkg::CmdRead, $urandom, $urandom, 6'(TableDepth - 1));
        for (int i = 0; i < 6; i++) begin
          queue_command(kot_pkg::CmdRead, $urandom, $urandom,
                        6'($urandom_range(0, TableDepth - 1)));
        end
        for (int i = 0; i < 6; i++) begin
          queue_command(kot_pkg::CmdFind, base + $urandom_range(0, TableDepth + 3) * stride,
                        $urandom, 6'($urandom));
        end
        for (int i = 0; i < 8; i++) begin
          queue_command(kot_pkg::CmdErase, base + $urandom_range(0, TableDepth - 1) * stride,
                        $urandom, 6'($urandom));
          queue_command(kot_pkg::CmdRead, $urandom, $urandom,
                        6'($urandom_range(0, TableDepth - 1)));
        end
        for (int i = 0; i < 4; i++) begin
          queue_command(kot_pkg::CmdInsert, base + $urandom_range(0, TableDepth + 3) * stride,
                        $urandom, 6'($urandom));
        end
      end else if (pick < 15) begin
        // noise: anything at all
        for (int i = 0; i < 10; i++) begin
          queue_command(3'($urandom), $urandom, $urandom, 6'($urandom));
        end
      end else begin
        for (int i = 0; i < 20; i++) begin
          pick = $urandom_range(0, 99);
          if (pick < 35) cmd = kot_pkg::CmdInsert;
          else if (pick < 55) cmd = kot_pkg::CmdFind;
          else if (pick < 72) cmd = kot_pkg::CmdErase;
          else if (pick < 96) cmd = kot_pkg::CmdRead;
          else if (pick < 97) cmd = kot_pkg::CmdClear;
          else cmd = 3'($urandom_range(CmdUnknownLo, CmdUnknownHi));
          queue_command(cmd, key_pool[$urandom_range(0, PoolSize - 1)], $urandom,
                        ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 15)));
        end
      end
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    do @(negedge clk_i);
    while (pending_commands.size() > 0 || in_valid_i || expected_results.size() > 0);
    repeat (DrainCycles) @(negedge clk_i);

    $display("covered %0d commands: %0d insert, %0d find, %0d erase, %0d read,",
             accepted_beats, cmd_tally[kot_pkg::CmdInsert], cmd_tally[kot_pkg::CmdFind],
             cmd_tally[kot_pkg::CmdErase], cmd_tally[kot_pkg::CmdRead]);
    $display("  %0d clear, %0d other; checked %0d results: %0d ok, %0d not found,",
             cmd_tally[kot_pkg::CmdClear], cmd_tally[5] + cmd_tally[6] + cmd_tally[7],
             results_checked, status_tally[kot_pkg::StOk], status_tally[kot_pkg::StNotFound]);
    $display("  %0d duplicate, %0d full; %0d errors",
             status_tally[kot_pkg::StDuplicate], status_tally[kot_pkg::StFull], error_count);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("PASS int_key_ordered_table");
    end else begin
      $display("FAIL int_key_ordered_table");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/kot_pkg.sv
rtl/kot_store.sv
rtl/kot_seq.sv
rtl/int_key_ordered_table.sv
bench/int_key_ordered_table_tb.sv
